// File: rtl/bbda_pkg.sv
package bbda_pkg;

  // Source and output geometry limits
  localparam int MaxWidth   = 128;
  localparam int MaxHeight  = 128;
  localparam int MaxOutCols = 64;
  localparam int ScaleMin   = 2;
  localparam int ScaleMax   = 16;
  localparam int SumMax     = 511;

  // Field and counter widths
  localparam int PixW    = 8;
  localparam int AlphaW  = 8;
  localparam int ColW    = $clog2(MaxOutCols);
  localparam int RowW    = 6;
  localparam int SumW    = 9;
  localparam int WidthW  = 8;
  localparam int HeightW = 8;
  localparam int ScaleW  = 5;
  localparam int ByteW   = $clog2(MaxWidth / PixW);
  localparam int SrcRowW = $clog2(MaxHeight);
  localparam int BandW   = $clog2(ScaleMax);
  localparam int SubW    = $clog2(ScaleMax);
  localparam int BitW    = $clog2(PixW);

  // Divide unit widths: count*255 over scale squared, and pixel x over scale
  localparam int NumW   = SumW + AlphaW;
  localparam int DenW   = 2 * (ScaleW - 1) + 1;
  localparam int QuotW  = 8;
  localparam int StepW  = $clog2(QuotW);

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgScale  = 2'd2
  } cfg_idx_e;

  localparam logic [WidthW-1:0]  WidthRst  = 8'd8;
  localparam logic [HeightW-1:0] HeightRst = 8'd8;
  localparam logic [ScaleW-1:0]  ScaleRst  = 5'd8;

  // Clamped configuration seen by the datapath
  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [ScaleW-1:0]  scale;
    logic [ByteW:0]     bytes_per_row;
    logic               written;
  } cfg_t;

  // Divide unit request and response
  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   dividend;
    logic [DenW-1:0]   divisor;
    logic [StepW-1:0]  top;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QuotW-1:0]  quotient;
    logic [NumW-1:0]   remainder;
  } div_rsp_t;

endpackage

// File: rtl/bbda_pix_if.sv
interface bbda_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bbda_pkg::PixW-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

// File: rtl/bbda_res_if.sv
interface bbda_res_if;
  logic                        valid;
  logic                        ready;
  logic [bbda_pkg::AlphaW-1:0] alpha;
  logic [bbda_pkg::ColW-1:0]   out_col;
  logic [bbda_pkg::RowW-1:0]   out_row;
  logic                        row_last;
  logic                        image_last;

  modport source (output valid, output alpha, output out_col, output out_row,
                  output row_last, output image_last, input ready);
  modport sink (input valid, input alpha, input out_col, input out_row,
                input row_last, input image_last, output ready);
endinterface

// File: rtl/bbda_cfg_if.sv
interface bbda_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bbda_pkg::CfgIdxW-1:0]  index;
  logic [bbda_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/bitmap_box_downscale_alpha.sv
// Box-filter downscaler from a 1-bit bitmap to 8-bit alpha. Feed packed source
// bytes in row order, bit 7 leftmost, ceil(width/8) bytes per row. Each byte
// keeps the input closed after acceptance while its 8 pixels are walked, with
// one column-sum RAM read for every output column the byte touches (one to
// four), since all column sums live in one RAM with a single read port. After
// a configuration write in the middle of a row, the next byte first passes
// through the shared divide unit to find its starting column. The byte that
// ends a band (scale_factor rows, or the last image row) is followed by a burst
// of ceil(width/scale_factor) results; each alpha comes from an 8-step pass of
// the shared divide unit as floor(count*255/scale_factor^2), or is 255 without
// a divide when it saturates. No input is taken during the burst, but the next
// byte is taken while the last result still waits in the output register.
// Column sums are cleared through per-entry valid flags, so there is no
// clearing pass after reset or per band.
module bitmap_box_downscale_alpha_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbda_cfg_if.sink   cfg_i,
  bbda_pix_if.sink   pix_i,
  bbda_res_if.source res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_PIX,
    S_EM_RD,
    S_EM_CHK,
    S_EM_DIV,
    S_EM_OUT
  } state_e;

  localparam int NumPad = bbda_pkg::NumW - bbda_pkg::ByteW - bbda_pkg::BitW;
  localparam int DenPad = bbda_pkg::DenW - bbda_pkg::ScaleW;

  bbda_pkg::cfg_t     cfg;
  bbda_pkg::div_req_t div_req;
  bbda_pkg::div_rsp_t div_rsp;

  state_e                           state_q, state_d;
  logic [bbda_pkg::PixW-1:0]        pix_q, pix_d;
  logic [bbda_pkg::BitW-1:0]        bit_q, bit_d;
  logic [bbda_pkg::BitW:0]          cnt_q, cnt_d;
  logic [bbda_pkg::ColW-1:0]        col_q, col_d;
  logic [bbda_pkg::SubW-1:0]        sub_q, sub_d;
  logic                             resync_q, resync_d;
  logic [bbda_pkg::ByteW-1:0]       bir_q, bir_d;
  logic [bbda_pkg::SrcRowW-1:0]     src_q, src_d;
  logic [bbda_pkg::BandW-1:0]       rib_q, rib_d;
  logic [bbda_pkg::RowW-1:0]        orow_q, orow_d;
  logic [bbda_pkg::RowW-1:0]        erow_q, erow_d;
  logic                             elast_q, elast_d;
  logic [bbda_pkg::ColW-1:0]        ecol_q, ecol_d;
  logic [bbda_pkg::WidthW-1:0]      base_q, base_d;
  logic [bbda_pkg::AlphaW-1:0]      ealpha_q, ealpha_d;
  logic [bbda_pkg::MaxOutCols-1:0]  vld_q, vld_d;

  logic                             ovalid_q, ovalid_d;
  logic [bbda_pkg::AlphaW-1:0]      oalpha_q, oalpha_d;
  logic [bbda_pkg::ColW-1:0]        ocol_q, ocol_d;
  logic [bbda_pkg::RowW-1:0]        orowo_q, orowo_d;
  logic                             orl_q, orl_d;
  logic                             oil_q, oil_d;

  logic                             ram_we;
  logic                             ram_re;
  logic [bbda_pkg::ColW-1:0]        ram_raddr;
  logic [bbda_pkg::SumW-1:0]        ram_wdata;
  logic [bbda_pkg::SumW-1:0]        ram_rdata;

  logic                             pix_acc;
  logic                             out_free;
  logic [bbda_pkg::ByteW+bbda_pkg::BitW-1:0] pos_x;
  logic                             hit;
  logic [bbda_pkg::BitW:0]          cnt_inc;
  logic                             sub_wrap;
  logic                             seg_end;
  logic [bbda_pkg::SumW-1:0]        old_pix;
  logic [bbda_pkg::SumW:0]          sum_ext;
  logic [bbda_pkg::ByteW:0]         bir_next;
  logic [bbda_pkg::BandW:0]         rib_next;
  logic [bbda_pkg::HeightW-1:0]     src_next;
  logic                             last_row;
  logic                             emit;
  logic [bbda_pkg::SumW-1:0]        old_em;
  logic [bbda_pkg::NumW-1:0]        num;
  logic [2*bbda_pkg::ScaleW-1:0]    sq_full;
  logic [bbda_pkg::DenW-1:0]        den;
  logic                             sat;
  logic [bbda_pkg::WidthW:0]        base_next;
  logic                             row_end_col;

  bbda_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bbda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bbda_ram #(
    .Width (bbda_pkg::SumW),
    .Depth (bbda_pkg::MaxOutCols)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pix_i.ready = (state_q == S_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign out_free    = !ovalid_q || res_o.ready;

  // RAM read address: walked column during pixels, emitted column at band end
  assign ram_re    = (state_q == S_RD) || (state_q == S_EM_RD);
  assign ram_raddr = (state_q == S_EM_RD) ? ecol_q : col_q;

  // Pixel walk terms
  assign pos_x    = {bir_q, bit_q};
  assign hit      = ({1'b0, pos_x} < cfg.width) && pix_q[3'd7 - bit_q];
  assign cnt_inc  = cnt_q + {{bbda_pkg::BitW{1'b0}}, hit};
  assign sub_wrap = ({1'b0, sub_q} + bbda_pkg::ScaleW'(1)) >= cfg.scale;
  assign seg_end  = sub_wrap || (bit_q == bbda_pkg::BitW'(bbda_pkg::PixW - 1));
  assign old_pix  = vld_q[col_q] ? ram_rdata : '0;
  assign sum_ext  = {1'b0, old_pix} + (bbda_pkg::SumW + 1)'(cnt_inc);
  assign ram_wdata = (sum_ext > (bbda_pkg::SumW + 1)'(bbda_pkg::SumMax)) ?
                     bbda_pkg::SumW'(bbda_pkg::SumMax) : sum_ext[bbda_pkg::SumW-1:0];

  // Row and band end terms
  assign bir_next = {1'b0, bir_q} + (bbda_pkg::ByteW + 1)'(1);
  assign rib_next = {1'b0, rib_q} + (bbda_pkg::BandW + 1)'(1);
  assign src_next = bbda_pkg::HeightW'(src_q) + bbda_pkg::HeightW'(1);
  assign last_row = src_next >= cfg.height;
  assign emit     = ({1'b0, rib_next} >= (bbda_pkg::BandW + 2)'(cfg.scale)) || last_row;

  // Emission terms: count*255 against scale squared
  assign old_em    = vld_q[ecol_q] ? ram_rdata : '0;
  assign num       = {old_em, {bbda_pkg::AlphaW{1'b0}}} - bbda_pkg::NumW'(old_em);
  assign sq_full   = cfg.scale * cfg.scale;
  assign den       = sq_full[bbda_pkg::DenW-1:0];
  assign sat       = num >= {den, {bbda_pkg::AlphaW{1'b0}}};
  assign base_next = {1'b0, base_q} + (bbda_pkg::WidthW + 1)'(cfg.scale);
  assign row_end_col = (base_next >= {1'b0, cfg.width}) ||
                       (ecol_q == bbda_pkg::ColW'(bbda_pkg::MaxOutCols - 1));

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    pix_d    = pix_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    sub_d    = sub_q;
    resync_d = resync_q;
    bir_d    = bir_q;
    src_d    = src_q;
    rib_d    = rib_q;
    orow_d   = orow_q;
    erow_d   = erow_q;
    elast_d  = elast_q;
    ecol_d   = ecol_q;
    base_d   = base_q;
    ealpha_d = ealpha_q;
    vld_d    = vld_q;
    ovalid_d = ovalid_q && !res_o.ready;
    oalpha_d = oalpha_q;
    ocol_d   = ocol_q;
    orowo_d  = orowo_q;
    orl_d    = orl_q;
    oil_d    = oil_q;
    ram_we   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {{NumPad{1'b0}}, bir_q, {bbda_pkg::BitW{1'b0}}};
    div_req.divisor  = {{DenPad{1'b0}}, cfg.scale};
    div_req.top      = bbda_pkg::StepW'(bbda_pkg::ByteW + bbda_pkg::BitW - 1);

    case (state_q)
      S_IDLE: begin
        if (pix_acc) begin
          pix_d = pix_i.pixel_byte;
          bit_d = '0;
          if (bir_q == '0) begin
            col_d    = '0;
            sub_d    = '0;
            resync_d = 1'b0;
            state_d  = S_RD;
          end else if (resync_q) begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          col_d    = div_rsp.quotient[bbda_pkg::ColW-1:0];
          sub_d    = div_rsp.remainder[bbda_pkg::SubW-1:0];
          resync_d = 1'b0;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        cnt_d   = '0;
        state_d = S_PIX;
      end
      S_PIX: begin
        // Count this pixel and step the column walk
        cnt_d = cnt_inc;
        bit_d = bit_q + 1'b1;
        if (sub_wrap) begin
          sub_d = '0;
          col_d = col_q + 1'b1;
        end else begin
          sub_d = sub_q + 1'b1;
        end
        if (seg_end) begin
          ram_we       = 1'b1;
          vld_d[col_q] = 1'b1;
        end
        if (bit_q == bbda_pkg::BitW'(bbda_pkg::PixW - 1)) begin
          if (bir_next < cfg.bytes_per_row) begin
            bir_d   = bir_next[bbda_pkg::ByteW-1:0];
            state_d = S_IDLE;
          end else begin
            // Row end: advance row counters, start the band burst if due
            bir_d   = '0;
            src_d   = last_row ? '0 : src_next[bbda_pkg::SrcRowW-1:0];
            rib_d   = emit ? '0 : rib_next[bbda_pkg::BandW-1:0];
            orow_d  = last_row ? '0 : (emit ? orow_q + 1'b1 : orow_q);
            erow_d  = orow_q;
            elast_d = last_row;
            ecol_d  = '0;
            base_d  = '0;
            state_d = emit ? S_EM_RD : S_IDLE;
          end
        end else if (seg_end) begin
          state_d = S_RD;
        end
      end
      S_EM_RD: begin
        state_d = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (sat) begin
          ealpha_d = '1;
          state_d  = S_EM_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num;
          div_req.divisor  = den;
          div_req.top      = bbda_pkg::StepW'(bbda_pkg::QuotW - 1);
          state_d          = S_EM_DIV;
        end
      end
      S_EM_DIV: begin
        if (div_rsp.done) begin
          ealpha_d = div_rsp.quotient;
          state_d  = S_EM_OUT;
        end
      end
      S_EM_OUT: begin
        // Hand the word to the output register once it is free
        if (out_free) begin
          ovalid_d = 1'b1;
          oalpha_d = ealpha_q;
          ocol_d   = ecol_q;
          orowo_d  = erow_q;
          orl_d    = row_end_col;
          oil_d    = row_end_col && elast_q;
          if (row_end_col) begin
            vld_d   = '0;
            state_d = S_IDLE;
          end else begin
            ecol_d  = ecol_q + 1'b1;
            base_d  = base_next[bbda_pkg::WidthW-1:0];
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A config write may move the column grid under a partly done row
    if (cfg.written) begin
      resync_d = 1'b1;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pix_q    <= '0;
      bit_q    <= '0;
      cnt_q    <= '0;
      col_q    <= '0;
      sub_q    <= '0;
      resync_q <= 1'b0;
      bir_q    <= '0;
      src_q    <= '0;
      rib_q    <= '0;
      orow_q   <= '0;
      erow_q   <= '0;
      elast_q  <= 1'b0;
      ecol_q   <= '0;
      base_q   <= '0;
      ealpha_q <= '0;
      vld_q    <= '0;
      ovalid_q <= 1'b0;
      oalpha_q <= '0;
      ocol_q   <= '0;
      orowo_q  <= '0;
      orl_q    <= 1'b0;
      oil_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pix_q    <= pix_d;
      bit_q    <= bit_d;
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      sub_q    <= sub_d;
      resync_q <= resync_d;
      bir_q    <= bir_d;
      src_q    <= src_d;
      rib_q    <= rib_d;
      orow_q   <= orow_d;
      erow_q   <= erow_d;
      elast_q  <= elast_d;
      ecol_q   <= ecol_d;
      base_q   <= base_d;
      ealpha_q <= ealpha_d;
      vld_q    <= vld_d;
      ovalid_q <= ovalid_d;
      oalpha_q <= oalpha_d;
      ocol_q   <= ocol_d;
      orowo_q  <= orowo_d;
      orl_q    <= orl_d;
      oil_q    <= oil_d;
    end
  end

  assign res_o.valid      = ovalid_q;
  assign res_o.alpha      = oalpha_q;
  assign res_o.out_col    = ocol_q;
  assign res_o.out_row    = orowo_q;
  assign res_o.row_last   = orl_q;
  assign res_o.image_last = oil_q;

endmodule

// File: rtl/bbda_ram.sv
module bbda_ram #(
  parameter int Width = 9,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/bbda_div.sv
module bbda_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbda_pkg::div_req_t req_i,
  output bbda_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [bbda_pkg::NumW-1:0]     rem_q;
  logic [bbda_pkg::DenW-1:0]     den_q;
  logic [bbda_pkg::QuotW-1:0]    quot_q;
  logic [bbda_pkg::StepW-1:0]    step_q;
  logic [bbda_pkg::NumW-1:0]     trial;
  logic                          fits;

  // Shifted divisor for the current quotient bit
  assign trial = {{(bbda_pkg::NumW - bbda_pkg::DenW){1'b0}}, den_q} << step_q;
  assign fits  = rem_q >= trial;

  // Control: one quotient bit per cycle, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: restoring shift-subtract
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      den_q  <= req_i.divisor;
      step_q <= req_i.top;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q          <= rem_q - trial;
        quot_q[step_q] <= 1'b1;
      end
      if (step_q != '0) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/bbda_cfg.sv
module bbda_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  bbda_cfg_if.sink         cfg_i,
  output bbda_pkg::cfg_t   cfg_o
);

  logic [bbda_pkg::WidthW-1:0]  width_q;
  logic [bbda_pkg::HeightW-1:0] height_q;
  logic [bbda_pkg::ScaleW-1:0]  scale_q;
  logic                         wr;
  logic [bbda_pkg::WidthW:0]    width_round;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  // Store written registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbda_pkg::WidthRst;
      height_q <= bbda_pkg::HeightRst;
      scale_q  <= bbda_pkg::ScaleRst;
    end else if (wr) begin
      case (bbda_pkg::cfg_idx_e'(cfg_i.index))
        bbda_pkg::CfgWidth:  width_q  <= cfg_i.data[bbda_pkg::WidthW-1:0];
        bbda_pkg::CfgHeight: height_q <= cfg_i.data[bbda_pkg::HeightW-1:0];
        bbda_pkg::CfgScale:  scale_q  <= cfg_i.data[bbda_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported ranges and derive bytes per row
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = bbda_pkg::WidthW'(1);
    end else if (width_q > bbda_pkg::WidthW'(bbda_pkg::MaxWidth)) begin
      cfg_o.width = bbda_pkg::WidthW'(bbda_pkg::MaxWidth);
    end else begin
      cfg_o.width = width_q;
    end

    if (height_q == '0) begin
      cfg_o.height = bbda_pkg::HeightW'(1);
    end else if (height_q > bbda_pkg::HeightW'(bbda_pkg::MaxHeight)) begin
      cfg_o.height = bbda_pkg::HeightW'(bbda_pkg::MaxHeight);
    end else begin
      cfg_o.height = height_q;
    end

    if (scale_q < bbda_pkg::ScaleW'(bbda_pkg::ScaleMin)) begin
      cfg_o.scale = bbda_pkg::ScaleW'(bbda_pkg::ScaleMin);
    end else if (scale_q > bbda_pkg::ScaleW'(bbda_pkg::ScaleMax)) begin
      cfg_o.scale = bbda_pkg::ScaleW'(bbda_pkg::ScaleMax);
    end else begin
      cfg_o.scale = scale_q;
    end

    width_round         = {1'b0, cfg_o.width} + (bbda_pkg::WidthW + 1)'(7);
    cfg_o.bytes_per_row =
        width_round[bbda_pkg::ByteW+bbda_pkg::BitW:bbda_pkg::BitW];
    cfg_o.written       = wr;
  end

endmodule

// File: rtl/bbda_chk.sv
module bbda_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid_i,
  input logic pix_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_row_last_i,
  input logic res_image_last_i
);

  // Hold a stalled result word
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  // Close the image only on the last column of a row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_image_last_i |-> res_row_last_i)
    else $error("image end flagged off a row end");

  // Keep input closed while a band burst is still open
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_row_last_i |-> !pix_ready_i)
    else $error("input taken during a band burst");

  // Go busy right after a source word is taken
  a_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("ready again right after a source word");

endmodule

bind bitmap_box_downscale_alpha_core bbda_chk u_bbda_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pix_valid_i      (pix_i.valid),
  .pix_ready_i      (pix_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_row_last_i   (res_o.row_last),
  .res_image_last_i (res_o.image_last)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bbda_pkg::*;

  localparam int RandomBytes  = 380;
  localparam int SettleCycles = 40;
  localparam int ReportLimit  = 10;
  localparam int IdlePercent  = 19;
  localparam int AlphaFull    = 255;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum int {InkRandom, InkFull, InkNone, InkSparse, InkDense} ink_e;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic              row_last;
    logic              image_last;
  } alpha_word_t;

  logic clk_i;
  logic rst_ni;

  bbda_cfg_if cfg_if ();
  bbda_pix_if pix_if ();
  bbda_res_if res_if ();

  bitmap_box_downscale_alpha_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  // Geometry registers and accumulator state as the block should hold them
  logic [WidthW-1:0]  geo_width;
  logic [HeightW-1:0] geo_height;
  logic [ScaleW-1:0]  geo_scale;
  logic [SumW-1:0]    col_sum [MaxOutCols];
  logic [ByteW-1:0]   byte_pos;
  logic [SrcRowW-1:0] src_row;
  logic [BandW-1:0]   band_row;
  logic [RowW-1:0]    out_row_cnt;

  logic [PixW-1:0] byte_q [$];
  alpha_word_t     alpha_q [$];
  alpha_word_t     got_word;
  alpha_word_t     want_word;
  logic            pix_took;
  logic            calm;
  int              errors;
  int              bytes_queued;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Accumulate one source byte; queue the band's alpha words when a band closes
  function automatic void downscale_byte(input logic [PixW-1:0] pix);
    int w, h, s, bpr, ncols, x, col, band, alpha;
    logic last_row;
    alpha_word_t word;
    w = clamp_int(int'(geo_width), 1, MaxWidth);
    h = clamp_int(int'(geo_height), 1, MaxHeight);
    s = clamp_int(int'(geo_scale), ScaleMin, ScaleMax);
    bpr = (w + 7) / 8;
    ncols = (w + s - 1) / s;
    if (ncols > MaxOutCols) ncols = MaxOutCols;

    for (int i = 0; i < PixW; i++) begin
      x = int'(byte_pos) * PixW + i;
      col = x / s;
      if (x < w && pix[PixW-1-i] && col < MaxOutCols) begin
        if (int'(col_sum[col]) < SumMax) col_sum[col]++;
      end
    end

    if (int'(byte_pos) + 1 < bpr) begin
      byte_pos++;
      return;
    end

    byte_pos = '0;
    band = int'(band_row) + 1;
    last_row = (int'(src_row) + 1 >= h);

    // Close the band: one word per output column, then clear the sums
    if (band >= s || last_row) begin
      for (int c = 0; c < ncols; c++) begin
        alpha = int'(col_sum[c]) * AlphaFull / (s * s);
        if (alpha > AlphaFull) alpha = AlphaFull;
        word.alpha      = AlphaW'(alpha);
        word.col        = ColW'(c);
        word.row        = out_row_cnt;
        word.row_last   = (c + 1 == ncols);
        word.image_last = (c + 1 == ncols) && last_row;
        alpha_q.push_back(word);
      end
      foreach (col_sum[k]) col_sum[k] = '0;
      band = 0;
      out_row_cnt++;
    end
    band_row = BandW'(band);

    if (last_row) begin
      src_row = '0;
      band_row = '0;
      out_row_cnt = '0;
    end else begin
      src_row++;
    end
  endfunction

  // Bytes still needed to close the image under the current geometry
  function automatic int bytes_to_image_end();
    int w, h, bpr, rest;
    w = clamp_int(int'(geo_width), 1, MaxWidth);
    h = clamp_int(int'(geo_height), 1, MaxHeight);
    bpr = (w + 7) / 8;
    rest = (int'(byte_pos) < bpr) ? bpr - int'(byte_pos) : 1;
    if (int'(src_row) + 1 < h) rest += (h - int'(src_row) - 1) * bpr;
    return rest;
  endfunction

  function automatic logic [PixW-1:0] make_byte(input ink_e mode);
    case (mode)
      InkFull:   return '1;
      InkNone:   return '0;
      InkSparse: return PixW'($urandom & $urandom & $urandom);
      InkDense:  return PixW'($urandom | $urandom);
      default:   return PixW'($urandom);
    endcase
  endfunction

  function automatic void queue_bytes(input int n, input ink_e mode);
    repeat (n) begin
      byte_q.push_back(make_byte(mode));
      bytes_queued++;
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every byte is taken and every word has come back, then let the block go quiet
  task automatic settle();
    while (byte_q.size() != 0 || alpha_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Source bytes: hold a word until taken, then advance or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_took) begin
      if (pix_took) void'(byte_q.pop_front());
      if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        pix_if.valid      <= 1'b1;
        pix_if.pixel_byte <= byte_q[0];
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= rst_ni && (calm || $urandom_range(99) >= IdlePercent);
  end

  // Watch all three channels at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_took <= 1'b0;
    end else begin
      pix_took <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) downscale_byte(pix_if.pixel_byte);

      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgWidth:  geo_width  = cfg_if.data;
          CfgHeight: geo_height = cfg_if.data;
          CfgScale:  geo_scale  = cfg_if.data[ScaleW-1:0];
          default: ;
        endcase
      end

      if (res_if.valid && res_if.ready) begin
        got_word.alpha      = res_if.alpha;
        got_word.col        = res_if.out_col;
        got_word.row        = res_if.out_row;
        got_word.row_last   = res_if.row_last;
        got_word.image_last = res_if.image_last;
        if (alpha_q.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("%0t: unexpected word alpha %0d col %0d row %0d last %b/%b", $realtime,
                     got_word.alpha, got_word.col, got_word.row, got_word.row_last,
                     got_word.image_last);
        end else begin
          want_word = alpha_q.pop_front();
          if (got_word.alpha !== want_word.alpha || got_word.col !== want_word.col ||
              got_word.row !== want_word.row || got_word.row_last !== want_word.row_last ||
              got_word.image_last !== want_word.image_last) begin
            errors++;
            if (errors <= ReportLimit)
              $display("%0t: mismatch exp alpha %0d col %0d row %0d last %b/%b, got %0d %0d %0d %b/%b",
                       $realtime, want_word.alpha, want_word.col, want_word.row,
                       want_word.row_last, want_word.image_last, got_word.alpha, got_word.col,
                       got_word.row, got_word.row_last, got_word.image_last);
          end
        end
      end
    end
  end

  initial begin
    int w_raw, h_raw, s_raw, wc, hc, bpr, cap, total, k, phase, target;
    ink_e mode;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CfgWidth;
    cfg_if.data       = '0;
    pix_if.valid      = 1'b0;
    pix_if.pixel_byte = '0;
    res_if.ready      = 1'b0;
    geo_width   = WidthRst;
    geo_height  = HeightRst;
    geo_scale   = ScaleRst;
    foreach (col_sum[i]) col_sum[i] = '0;
    byte_pos    = '0;
    src_row     = '0;
    band_row    = '0;
    out_row_cnt = '0;
    pix_took    = 1'b0;
    calm        = 1'b0;
    errors      = 0;
    bytes_queued = 0;
    phase       = 0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry 8x8 at scale 8: solid ink gives full coverage
    queue_bytes(8, InkFull);
    settle();

    // Two one-pixel images at scale 2: padding bits ignored, block partly outside
    write_reg(CfgWidth, 8'd1);
    write_reg(CfgHeight, 8'd1);
    write_reg(CfgScale, 8'd2);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h7F);
    bytes_queued += 2;
    settle();

    // Zero width, height and scale act as the minimum; the spare index is ignored
    write_reg(CfgWidth, 8'd0);
    write_reg(CfgHeight, 8'd0);
    write_reg(CfgScale, 8'd0);
    write_reg(CfgSpare, 8'hA5);
    byte_q.push_back(8'h80);
    bytes_queued++;
    settle();

    // Oversize width and scale act as 128 and 16
    write_reg(CfgWidth, 8'hFF);
    write_reg(CfgHeight, 8'd1);
    write_reg(CfgScale, 8'h1F);
    queue_bytes(16, InkDense);

    // Whole images with random geometry, some with a register change mid-image
    target = bytes_queued + RandomBytes;
    while (bytes_queued < target) begin
      settle();
      phase++;
      calm = (phase >= 4 && phase < 9);

      case ($urandom_range(0, 9))
        0:       w_raw = 1;
        1:       w_raw = MaxWidth;
        2:       w_raw = 0;
        3:       w_raw = $urandom_range(MaxWidth + 1, 255);
        default: w_raw = $urandom_range(1, 40);
      endcase
      wc = clamp_int(w_raw, 1, MaxWidth);
      bpr = (wc + 7) / 8;

      case ($urandom_range(0, 9))
        0:       h_raw = 1;
        1:       h_raw = 0;
        2:       h_raw = $urandom_range(0, 1) ? MaxHeight : $urandom_range(MaxHeight + 1, 255);
        default: h_raw = $urandom_range(1, 12);
      endcase
      hc = clamp_int(h_raw, 1, MaxHeight);
      cap = (bpr == 1) ? MaxHeight : 96;
      if (hc * bpr > cap) begin
        h_raw = $urandom_range(1, cap / bpr);
        hc = h_raw;
      end

      case ($urandom_range(0, 9))
        0:       s_raw = ScaleMin;
        1:       s_raw = ScaleMax;
        2:       s_raw = $urandom_range(0, ScaleMin - 1);
        3:       s_raw = $urandom_range(ScaleMax + 1, 31);
        default: s_raw = $urandom_range(ScaleMin, ScaleMax);
      endcase

      write_reg(CfgWidth, w_raw[7:0]);
      write_reg(CfgHeight, h_raw[7:0]);
      write_reg(CfgScale, {3'($urandom_range(0, 7)), s_raw[4:0]});

      mode = ink_e'($urandom_range(0, 4));
      total = hc * bpr;
      if (total > 1 && $urandom_range(0, 3) == 0) begin
        // Change one register partway through, then finish the image
        if ($urandom_range(0, 1)) mode = InkFull;
        k = $urandom_range(1, total - 1);
        queue_bytes(k, mode);
        settle();
        case ($urandom_range(0, 3))
          0:       write_reg(CfgWidth, 8'($urandom_range(0, 48)));
          1:       write_reg(CfgHeight, 8'($urandom_range(0, hc + 2)));
          default: write_reg(CfgScale, $urandom_range(0, 1) ? 8'd2 : 8'($urandom));
        endcase
        queue_bytes(bytes_to_image_end(), mode);
      end else begin
        queue_bytes(total, mode);
      end
    end

    calm = 1'b0;
    settle();
    if (errors == 0 && alpha_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/bbda_pkg.sv
rtl/bbda_pix_if.sv
rtl/bbda_res_if.sv
rtl/bbda_cfg_if.sv
rtl/bbda_ram.sv
rtl/bbda_div.sv
rtl/bbda_cfg.sv
rtl/bitmap_box_downscale_alpha.sv
rtl/bbda_chk.sv
verif/tb_top.sv
